@@ sv/multilevel_feedback_scheduler_defines.svh @@
// Assertion macros for the multilevel feedback scheduler.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define MLFS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlfs assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define MLFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlfs assertion failed");

`else

`define MLFS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MLFS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/mlfs_pkg.sv @@
// Shared sizes, codes, structs and helper functions of the multilevel feedback scheduler.
// No dependencies; used by every module of the block.
package mlfs_pkg;

   // Sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_LEVELS  = 4;
   localparam int SLOTS       = QUEUE_DEPTH + 1;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int COUNT_W     = $clog2(SLOTS + 1);
   localparam int LEVEL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int TOTAL_W     = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths
   localparam int ID_W        = 8;
   localparam int TICKS_W     = 16;
   localparam int QUANT_W     = 8;
   localparam int OUT_LEVEL_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);

   // Request function codes
   typedef enum logic {
      FUNC_TICK    = 1'b0,
      FUNC_ARRIVAL = 1'b1
   } func_type;

   // Control register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUANTUM_L1 = 2'd0,
      CSR_QUANTUM_L2 = 2'd1,
      CSR_QUANTUM_L3 = 2'd2
   } csr_index_type;

   typedef struct packed {
      func_type             func;
      logic [ID_W-1:0]      proc_id;
      logic [TICKS_W-1:0]   burst;
   } req_type;

   typedef struct packed {
      logic [QUANT_W-1:0] level1;
      logic [QUANT_W-1:0] level2;
      logic [QUANT_W-1:0] level3;
   } quant_cfg_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [ID_W-1:0]      push_id;
      logic [TICKS_W-1:0]   push_ticks;
   } fifo_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   count;
      logic [ID_W-1:0]      head_id;
      logic [TICKS_W-1:0]   head_ticks;
   } fifo_stat_type;

   typedef struct packed {
      logic                   running_valid;
      logic [ID_W-1:0]        running_id;
      logic [OUT_LEVEL_W-1:0] running_level;
      logic [TICKS_W-1:0]     remaining_time;
      logic                   arrival_refused;
   } rsp_type;

   // Circular slot pointer advance
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] ptr);
      return (ptr == SLOT_W'(SLOTS - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // Quantum of a level; a programmed zero behaves as one
   function automatic logic [QUANT_W-1:0] quantum_for(input logic [LEVEL_W-1:0] lv,
                                                      input quant_cfg_type   cfg);
      logic [QUANT_W-1:0] q;
      if (lv == '0) begin
         q = cfg.level1;
      end else if (lv == LEVEL_W'(1)) begin
         q = cfg.level2;
      end else begin
         q = cfg.level3;
      end
      return (q == '0) ? QUANT_W'(1) : q;
   endfunction

endpackage

@@ sv/mlfs_level_fifo.sv @@
// One priority level's FIFO of waiting processes (id and remaining ticks).
// Depends on mlfs_pkg; the head entry is held in a register read from the slot array.
module mlfs_level_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  mlfs_pkg::fifo_cmd_type cmd,
   output mlfs_pkg::fifo_stat_type stat
);
   import mlfs_pkg::*;

   logic [ID_W-1:0]    id_mem_ff    [SLOTS];
   logic [TICKS_W-1:0] ticks_mem_ff [SLOTS];

   logic [SLOT_W-1:0]  head_ff,  head_in;
   logic [SLOT_W-1:0]  tail_ff,  tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]    head_id_ff;
   logic [TICKS_W-1:0] head_ticks_ff;

   // Pointer and occupancy update
   always_comb begin
      head_in  = cmd.pop  ? next_slot(head_ff) : head_ff;
      tail_in  = cmd.push ? next_slot(tail_ff) : tail_ff;
      count_in = COUNT_W'(count_ff + COUNT_W'(cmd.push) - COUNT_W'(cmd.pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage, written at the tail
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         id_mem_ff[tail_ff]    <= cmd.push_id;
         ticks_mem_ff[tail_ff] <= cmd.push_ticks;
      end
   end

   // Head entry register; an entry written into the next head slot is passed straight on
   always_ff @(posedge clock) begin
      if (cmd.push && (tail_ff == head_in)) begin
         head_id_ff    <= cmd.push_id;
         head_ticks_ff <= cmd.push_ticks;
      end else begin
         head_id_ff    <= id_mem_ff[head_in];
         head_ticks_ff <= ticks_mem_ff[head_in];
      end
   end

   assign stat.count      = count_ff;
   assign stat.head_id    = head_id_ff;
   assign stat.head_ticks = head_ticks_ff;

endmodule

@@ sv/mlfs_sched_core.sv @@
// Scheduling step: arrival enqueue, demotion, priority poll and running-process state.
// Depends on mlfs_pkg, mlfs_level_fifo and the assertion macro header.
`include "multilevel_feedback_scheduler_defines.svh"

module mlfs_sched_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  mlfs_pkg::req_type       req,
   input  mlfs_pkg::quant_cfg_type quant,
   output mlfs_pkg::rsp_type       rsp
);
   import mlfs_pkg::*;

   // Running process and waiting count
   logic                 run_valid_ff, run_valid_in;
   logic [ID_W-1:0]      run_id_ff,    run_id_in;
   logic [TICKS_W-1:0]   run_ticks_ff, run_ticks_in;
   logic [LEVEL_W-1:0]   run_level_ff, run_level_in;
   logic [QUANT_W-1:0]   quantum_left_ff, quantum_left_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;

   fifo_cmd_type  cmd  [NUM_LEVELS];
   fifo_stat_type stat [NUM_LEVELS];

   logic                 is_tick, is_arrival, arrival_ok, refused;
   logic                 expired, poll, demote;
   logic [LEVEL_W-1:0]   demote_level;
   logic [ID_W-1:0]      push_id;
   logic [TICKS_W-1:0]   push_ticks;
   logic [NUM_LEVELS-1:0] push_vec, pop_vec, nonempty;
   logic                 found;
   logic [LEVEL_W-1:0]   sel;
   logic [ID_W-1:0]      sel_id;
   logic [TICKS_W-1:0]   sel_ticks;

   // One FIFO per level
   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
      mlfs_level_fifo u_fifo (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd[g]),
         .stat  (stat[g])
      );
   end

   // Request decode and demotion decision
   always_comb begin
      is_tick      = item_valid && (req.func == FUNC_TICK);
      is_arrival   = item_valid && (req.func == FUNC_ARRIVAL);
      arrival_ok   = is_arrival && (total_ff < TOTAL_W'(QUEUE_DEPTH)) && (req.burst != '0);
      refused      = is_arrival && !arrival_ok;
      expired      = (run_level_ff != LAST_LEVEL) && (quantum_left_ff == '0);
      poll         = is_tick && (!run_valid_ff || (run_ticks_ff == '0) || expired);
      demote       = poll && run_valid_ff && (run_ticks_ff != '0);
      demote_level = (run_level_ff < LAST_LEVEL) ? LEVEL_W'(run_level_ff + 1'b1) : LAST_LEVEL;
      push_id      = is_arrival ? req.proc_id : run_id_ff;
      push_ticks   = is_arrival ? req.burst   : run_ticks_ff;
   end

   // Enqueue and first non-empty level search (a level just pushed counts as filled)
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         push_vec[lv] = ((arrival_ok && (lv == 0)) ||
                         (demote && (demote_level == LEVEL_W'(lv)))) &&
                        (stat[lv].count < COUNT_W'(SLOTS));
         nonempty[lv] = (stat[lv].count != '0) || push_vec[lv];
      end
      for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
         if (nonempty[lv]) begin
            found = 1'b1;
            sel   = LEVEL_W'(lv);
         end
      end
      // Empty level being filled this cycle: take the pushed entry directly
      if (stat[sel].count == '0) begin
         sel_id    = push_id;
         sel_ticks = push_ticks;
      end else begin
         sel_id    = stat[sel].head_id;
         sel_ticks = stat[sel].head_ticks;
      end
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         pop_vec[lv]        = poll && found && (sel == LEVEL_W'(lv));
         cmd[lv].push       = push_vec[lv];
         cmd[lv].pop        = pop_vec[lv];
         cmd[lv].push_id    = push_id;
         cmd[lv].push_ticks = push_ticks;
      end
   end

   // Next running state, then one tick of work and quantum
   always_comb begin
      run_valid_in    = run_valid_ff;
      run_id_in       = run_id_ff;
      run_ticks_in    = run_ticks_ff;
      run_level_in    = run_level_ff;
      quantum_left_in = quantum_left_ff;
      if (poll) begin
         if (found) begin
            run_valid_in    = 1'b1;
            run_id_in       = sel_id;
            run_ticks_in    = sel_ticks;
            run_level_in    = sel;
            quantum_left_in = (sel == LAST_LEVEL) ? '0 : quantum_for(sel, quant);
         end else begin
            run_valid_in    = 1'b0;
            run_id_in       = '0;
            run_ticks_in    = '0;
            run_level_in    = '0;
            quantum_left_in = '0;
         end
      end
      if (is_tick && run_valid_in) begin
         if (run_ticks_in != '0) begin
            run_ticks_in = run_ticks_in - 1'b1;
         end
         if ((run_level_in != LAST_LEVEL) && (quantum_left_in != '0)) begin
            quantum_left_in = quantum_left_in - 1'b1;
         end
      end
      total_in = TOTAL_W'(total_ff + TOTAL_W'(|push_vec) - TOTAL_W'(|pop_vec));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff    <= 1'b0;
         run_id_ff       <= '0;
         run_ticks_ff    <= '0;
         run_level_ff    <= '0;
         quantum_left_ff <= '0;
         total_ff        <= '0;
      end else begin
         run_valid_ff    <= run_valid_in;
         run_id_ff       <= run_id_in;
         run_ticks_ff    <= run_ticks_in;
         run_level_ff    <= run_level_in;
         quantum_left_ff <= quantum_left_in;
         total_ff        <= total_in;
      end
   end

   // Result of this request, idle fields forced to zero
   always_comb begin
      rsp.running_valid   = run_valid_in;
      rsp.running_id      = run_valid_in ? run_id_in : '0;
      rsp.running_level   = run_valid_in ? OUT_LEVEL_W'(run_level_in) : '0;
      rsp.remaining_time  = run_valid_in ? run_ticks_in : '0;
      rsp.arrival_refused = refused;
   end

   // Idle scheduler carries no stale process
   `MLFS_ASSERT_IMPLY(a_idle_clear, clock, reset, !run_valid_ff,
      (run_id_ff == '0) && (run_ticks_ff == '0) && (run_level_ff == '0))
   // At most one level gives up its head per request
   `MLFS_ASSERT_IMPLY(a_single_pop, clock, reset, 1'b1, $onehot0(pop_vec))
   // A poll that finds work always leaves a process running
   `MLFS_ASSERT_NEXT(a_poll_runs, clock, reset, poll && found, run_valid_ff)
   // Run-to-completion level keeps no quantum
   `MLFS_ASSERT_IMPLY(a_last_no_quantum, clock, reset, run_level_ff == LAST_LEVEL,
      quantum_left_ff == '0)

endmodule

@@ sv/multilevel_feedback_scheduler.sv @@
// Multilevel feedback scheduler: one request per clock (tick or arrival), one result per
// request, strobed on rsp_strobe from the result register. busy is never raised, so a
// new request may be started every cycle; the request register and the result register
// bracket a single-pass scheduling step, and that step sets the one-request-per-cycle rate.
// The receiver cannot stall: rsp_strobe is high for a single cycle per result. The user
// must write quantum registers through csr_we/csr_index/csr_wdata only while no request
// is in flight; the block does not enforce it. Depends on mlfs_pkg and mlfs_sched_core.
module multilevel_feedback_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [mlfs_pkg::ID_W-1:0]           req_proc_id,
   input  logic [mlfs_pkg::TICKS_W-1:0]        req_burst,
   // Control register write port
   input  logic                                csr_we,
   input  logic [mlfs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mlfs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Result channel
   output logic                                rsp_strobe,
   output logic                                rsp_running_valid,
   output logic [mlfs_pkg::ID_W-1:0]           rsp_running_id,
   output logic [mlfs_pkg::OUT_LEVEL_W-1:0]    rsp_running_level,
   output logic [mlfs_pkg::TICKS_W-1:0]        rsp_remaining_time,
   output logic                                rsp_arrival_refused
);
   import mlfs_pkg::*;

   logic          req_valid_ff;
   req_type       req_ff, req_in;
   quant_cfg_type quant_ff, quant_in;
   logic          rsp_strobe_ff;
   rsp_type       rsp_ff, rsp_in;

   // Every request is taken as it comes
   assign busy = 1'b0;

   // Request register
   always_comb begin
      req_in.func    = func_type'(req_func);
      req_in.proc_id = req_proc_id;
      req_in.burst   = req_burst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_in;
      end
   end

   // Quantum register decode
   always_comb begin
      quant_in = quant_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUANTUM_L1: quant_in.level1 = QUANT_W'(csr_wdata);
            CSR_QUANTUM_L2: quant_in.level2 = QUANT_W'(csr_wdata);
            CSR_QUANTUM_L3: quant_in.level3 = QUANT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff.level1 <= QUANT_W'(1);
         quant_ff.level2 <= QUANT_W'(2);
         quant_ff.level3 <= QUANT_W'(4);
      end else begin
         quant_ff <= quant_in;
      end
   end

   // Scheduling step
   mlfs_sched_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid_ff),
      .req        (req_ff),
      .quant      (quant_ff),
      .rsp        (rsp_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_running_valid   = rsp_ff.running_valid;
   assign rsp_running_id      = rsp_ff.running_id;
   assign rsp_running_level   = rsp_ff.running_level;
   assign rsp_remaining_time  = rsp_ff.remaining_time;
   assign rsp_arrival_refused = rsp_ff.arrival_refused;

endmodule
